// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define OWTM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent follows.
`define OWTM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/owtm_pkg.sv =====
// ----------------------------------------------------------------------------
// owtm_pkg
// Constants, state codes, state record and sequencing helpers of the
// 1-Wire temperature master.
// ----------------------------------------------------------------------------
package owtm_pkg;

  // Timer and register widths.
  localparam int TIMER_BITS = 10;
  localparam int CFG_W      = 10;
  localparam int NUM_CFG    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int DUR_W      = ((CFG_W > TIMER_BITS) ? CFG_W : TIMER_BITS) + 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_RECOV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SLOT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_SLOT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd6;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd500;
  localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd40;
  localparam logic [CFG_W-1:0] RST_RESET_RECOV   = 10'd500;
  localparam logic [CFG_W-1:0] RST_SHORT_SLOT    = 10'd2;
  localparam logic [CFG_W-1:0] RST_LONG_SLOT     = 10'd60;
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd12;
  localparam logic [CFG_W-1:0] RST_READ_TAIL     = 10'd50;

  // Command codes.
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_RESET   = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_MEASURE = 3'd4;

  // Bus phases.
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_RHIGH  = 4'd1;
  localparam logic [3:0] PH_RLOW   = 4'd2;
  localparam logic [3:0] PH_RWAIT  = 4'd3;
  localparam logic [3:0] PH_RRECOV = 4'd4;
  localparam logic [3:0] PH_WLOW   = 4'd5;
  localparam logic [3:0] PH_WHIGH  = 4'd6;
  localparam logic [3:0] PH_DLOW   = 4'd7;
  localparam logic [3:0] PH_DWAIT  = 4'd8;
  localparam logic [3:0] PH_DTAIL  = 4'd9;

  // Bus operations.
  localparam logic [1:0] OP_END   = 2'd0;
  localparam logic [1:0] OP_RESET = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // ROM and function command bytes.
  localparam logic [7:0] ROM_SKIP     = 8'hCC;
  localparam logic [7:0] FN_CONVERT   = 8'h44;
  localparam logic [7:0] FN_READ_SCR  = 8'hBE;

  // Sequencer state.
  typedef struct packed {
    logic [3:0]            phase;
    logic [TIMER_BITS-1:0] cnt;
    logic [2:0]            bidx;
    logic [7:0]            shift;
    logic [3:0]            step;
    logic [2:0]            actcmd;
    logic [15:0]           result;
    logic                  err;
  } st_t;

  // Operation of the measurement sequence at a given step.
  function automatic logic [1:0] meas_op_f(logic [3:0] step);
    logic [1:0] op;
    case (step) inside
      4'd0, 4'd3:             op = OP_RESET;
      4'd1, 4'd2, 4'd4, 4'd5: op = OP_WRITE;
      4'd6, 4'd7:             op = OP_READ;
      default:                op = OP_END;
    endcase
    return op;
  endfunction

  // Byte written by the measurement sequence at a given step.
  function automatic logic [7:0] meas_byte_f(logic [3:0] step);
    logic [7:0] b;
    case (step) inside
      4'd1, 4'd4: b = ROM_SKIP;
      4'd2:       b = FN_CONVERT;
      4'd5:       b = FN_READ_SCR;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  // Phase length in ticks: zero counts as one, long values clamp to the timer.
  function automatic logic [DUR_W-1:0] dur_f(logic [CFG_W-1:0] v);
    logic [DUR_W-1:0] d;
    d = DUR_W'(v);
    if (d == '0) d = DUR_W'(1);
    if (d > (DUR_W'(1) << TIMER_BITS)) d = DUR_W'(1) << TIMER_BITS;
    return d;
  endfunction

  // Starts the operation at the current step, or ends the command.
  function automatic st_t launch_f(st_t s, logic [7:0] wbyte);
    st_t        r;
    logic [1:0] op;
    logic [7:0] b;
    r  = s;
    op = OP_END;
    b  = wbyte;
    unique case (s.actcmd)
      CMD_RESET:   op = (s.step == 4'd0) ? OP_RESET : OP_END;
      CMD_WRITE:   op = (s.step == 4'd0) ? OP_WRITE : OP_END;
      CMD_READ:    op = (s.step == 4'd0) ? OP_READ : OP_END;
      CMD_MEASURE: begin
        op = meas_op_f(s.step);
        b  = meas_byte_f(s.step);
      end
      default:     op = OP_END;
    endcase
    r.bidx = 3'd0;
    r.cnt  = '0;
    unique case (op)
      OP_RESET: r.phase = PH_RHIGH;
      OP_WRITE: begin
        r.shift = b;
        r.phase = PH_WLOW;
      end
      OP_READ:  begin
        r.shift = 8'h00;
        r.phase = PH_DLOW;
      end
      default:  r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/one_wire_temperature_master.sv =====
// ----------------------------------------------------------------------------
// one_wire_temperature_master
// Tick-driven 1-Wire bus master with reset/presence, byte write, byte read
// and a full temperature measurement sequence.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Word
// in        input      in_valid_i/in_ready_o  cmd, write_data, line_in (one tick)
// out       output     out_valid_o/out_ready_i line, busy, done, status, value
// cfg       input      cfg_we_i               cfg_index_i, cfg_data_i
//
// The sequencer state and the result register update together on each taken
// tick word, so a new word is taken every cycle unless the result register stalls.
// The only stall comes from the result register: a word is taken when the
// result register is empty or is being taken in the same cycle.
// Reset clears the sequencer to idle, empties the result register and loads
// the default bus timings.
// ----------------------------------------------------------------------------
module one_wire_temperature_master
  import owtm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           cmd_i,
  input  logic [7:0]           write_data_i,
  input  logic                 line_in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 line_drive_o,
  output logic                 line_level_o,
  output logic                 busy_res_o,
  output logic                 done_res_o,
  output logic                 status_o,
  output logic [15:0]          read_value_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

`include "assert_macros.svh"

  logic [CFG_W-1:0] cfg_q [NUM_CFG];
  st_t              state_q, state_d;
  logic             out_valid_q;
  logic             line_drive_q, line_level_q, busy_q, done_q, status_q;
  logic [15:0]      value_q;

  logic             in_acc;
  logic             start;
  logic             running;
  logic             ph_end;
  logic             op_fin;
  logic             was_read;
  logic             bit_v;
  logic             drv, lvl, done_v;
  logic [3:0]       ph;
  logic [DUR_W-1:0] dsel;
  logic [DUR_W-1:0] cnt_ext;

  // Handshake: the result register parts the two sides.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[CFG_RESET_LOW]     <= RST_RESET_LOW;
      cfg_q[CFG_PRESENCE_WAIT] <= RST_PRESENCE_WAIT;
      cfg_q[CFG_RESET_RECOV]   <= RST_RESET_RECOV;
      cfg_q[CFG_SHORT_SLOT]    <= RST_SHORT_SLOT;
      cfg_q[CFG_LONG_SLOT]     <= RST_LONG_SLOT;
      cfg_q[CFG_READ_SAMPLE]   <= RST_READ_SAMPLE;
      cfg_q[CFG_READ_TAIL]     <= RST_READ_TAIL;
    end else if (cfg_we_i && (cfg_index_i < CFG_IDX_W'(NUM_CFG))) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Next state and line drive for one tick.
  always_comb begin
    state_d  = state_q;
    drv      = 1'b1;
    lvl      = 1'b1;
    op_fin   = 1'b0;
    was_read = 1'b0;
    dsel     = DUR_W'(1);

    // A command is only taken while idle; it starts its first phase now.
    start = (state_q.phase == PH_IDLE) && (cmd_i >= CMD_RESET) && (cmd_i <= CMD_MEASURE);
    if (start) begin
      state_d.actcmd = cmd_i;
      state_d.step   = 4'd0;
      state_d.err    = 1'b0;
      state_d.result = 16'h0000;
      state_d        = launch_f(state_d, write_data_i);
    end

    ph      = state_d.phase;
    bit_v   = state_d.shift[0];
    running = (ph != PH_IDLE) && (ph <= PH_DTAIL);

    // Line drive and length of the current phase.
    unique case (ph)
      PH_RHIGH:  dsel = dur_f(cfg_q[CFG_SHORT_SLOT]);
      PH_RLOW:   begin
        lvl  = 1'b0;
        dsel = dur_f(cfg_q[CFG_RESET_LOW]);
      end
      PH_RWAIT:  begin
        drv  = 1'b0;
        lvl  = 1'b0;
        dsel = dur_f(cfg_q[CFG_PRESENCE_WAIT]);
      end
      PH_RRECOV: begin
        drv  = 1'b0;
        lvl  = 1'b0;
        dsel = dur_f(cfg_q[CFG_RESET_RECOV]);
      end
      PH_WLOW:   begin
        lvl  = 1'b0;
        dsel = bit_v ? dur_f(cfg_q[CFG_SHORT_SLOT]) : dur_f(cfg_q[CFG_LONG_SLOT]);
      end
      PH_WHIGH:  dsel = bit_v ? dur_f(cfg_q[CFG_LONG_SLOT]) : dur_f(cfg_q[CFG_SHORT_SLOT]);
      PH_DLOW:   begin
        lvl  = 1'b0;
        dsel = dur_f(cfg_q[CFG_SHORT_SLOT]);
      end
      PH_DWAIT:  begin
        drv  = 1'b0;
        lvl  = 1'b0;
        dsel = dur_f(cfg_q[CFG_READ_SAMPLE]);
      end
      PH_DTAIL:  begin
        drv  = 1'b0;
        lvl  = 1'b0;
        dsel = dur_f(cfg_q[CFG_READ_TAIL]);
      end
      default:   state_d.phase = PH_IDLE;
    endcase

    // Phase timer: count up until the last tick of the phase.
    cnt_ext = DUR_W'(state_d.cnt) + DUR_W'(1);
    ph_end  = running && (cnt_ext >= dsel);
    if (running && !ph_end) begin
      state_d.cnt = state_d.cnt + TIMER_BITS'(1);
    end

    // Phase transitions and line samples on the last tick.
    if (ph_end) begin
      state_d.cnt = '0;
      case (ph)
        PH_RHIGH:  state_d.phase = PH_RLOW;
        PH_RLOW:   state_d.phase = PH_RWAIT;
        PH_RWAIT:  begin
          state_d.err   = line_in_i;
          state_d.phase = PH_RRECOV;
        end
        PH_RRECOV: op_fin = 1'b1;
        PH_WLOW:   state_d.phase = PH_WHIGH;
        PH_WHIGH:  begin
          state_d.shift = {1'b0, state_d.shift[7:1]};
          if (state_d.bidx == 3'd7) begin
            op_fin = 1'b1;
          end else begin
            state_d.bidx  = state_d.bidx + 3'd1;
            state_d.phase = PH_WLOW;
          end
        end
        PH_DLOW:   state_d.phase = PH_DWAIT;
        PH_DWAIT:  begin
          state_d.shift = {line_in_i, state_d.shift[7:1]};
          state_d.phase = PH_DTAIL;
        end
        PH_DTAIL:  begin
          if (state_d.bidx == 3'd7) begin
            op_fin   = 1'b1;
            was_read = 1'b1;
          end else begin
            state_d.bidx  = state_d.bidx + 3'd1;
            state_d.phase = PH_DLOW;
          end
        end
        default:   state_d.phase = PH_IDLE;
      endcase
    end

    // End of one bus operation: store a read byte, then go on or stop.
    if (op_fin) begin
      if (was_read) begin
        if ((state_d.actcmd == CMD_MEASURE) && (state_d.step == 4'd7)) begin
          state_d.result[15:8] = state_d.shift;
        end else begin
          state_d.result[7:0] = state_d.shift;
        end
      end
      if (state_d.err) begin
        state_d.phase = PH_IDLE;
        state_d.cnt   = '0;
      end else begin
        state_d.step = state_d.step + 4'd1;
        state_d      = launch_f(state_d, 8'h00);
      end
    end

    done_v = running && (state_d.phase == PH_IDLE);
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_drive_q <= drv;
      line_level_q <= lvl;
      busy_q       <= (state_d.phase != PH_IDLE);
      done_q       <= done_v;
      status_q     <= state_d.err;
      value_q      <= state_d.result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_drive_o = line_drive_q;
  assign line_level_o = line_level_q;
  assign busy_res_o   = busy_q;
  assign done_res_o   = done_q;
  assign status_o     = status_q;
  assign read_value_o = value_q;

  // Assertions.
  `OWTM_ASSERT_IMP(a_done_not_busy, out_valid_o, !(busy_res_o && done_res_o), "done while busy")
  `OWTM_ASSERT_IMP(a_released_low, out_valid_o && !line_drive_o, !line_level_o, "released line with level")
  `OWTM_ASSERT_NXT(a_idle_tick, in_acc && (state_q.phase == PH_IDLE) && (cmd_i == CMD_TICK),
                   !busy_res_o && !done_res_o && line_drive_o && line_level_o, "idle tick misbehaves")

endmodule

// ===== test/bus_master_checker.sv =====
// ----------------------------------------------------------------------------
// bus_master_checker
// Watches the tick, result and register channels of the 1-Wire temperature
// master. It keeps its own model of the bus sequencer and the timing
// registers, works out the result word of every accepted tick word, and
// compares each accepted result word with the oldest one still pending.
// ----------------------------------------------------------------------------
module bus_master_checker
  import owtm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [2:0]           cmd_i,
  input  logic [7:0]           write_data_i,
  input  logic                 line_in_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 line_drive_i,
  input  logic                 line_level_i,
  input  logic                 busy_res_i,
  input  logic                 done_res_i,
  input  logic                 status_i,
  input  logic [15:0]          read_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One result word as the block reports it for a tick.
  typedef struct packed {
    logic        drive;
    logic        level;
    logic        busy;
    logic        done;
    logic        status;
    logic [15:0] value;
  } tick_result_t;

  // Timing registers and sequencer state of the model.
  logic [CFG_W-1:0]      timing [NUM_CFG];
  logic [3:0]            bus_phase;
  logic [TIMER_BITS-1:0] phase_ticks;
  logic [2:0]            bit_pos;
  logic [7:0]            shreg;
  logic [3:0]            seq_step;
  logic [2:0]            cur_cmd;
  logic [15:0]           value_acc;
  logic                  no_presence;
  logic                  cmd_done;

  tick_result_t expected_words [$];

  // Length of a phase in ticks: zero counts as one, the timer range caps it.
  function automatic int unsigned ticks_of(logic [CFG_IDX_W-1:0] idx);
    int unsigned len;
    len = timing[idx];
    if (len == 0) len = 1;
    if (len > (32'd1 << TIMER_BITS)) len = 32'd1 << TIMER_BITS;
    return len;
  endfunction

  function automatic void goto_phase(logic [3:0] ph);
    bus_phase   = ph;
    phase_ticks = '0;
  endfunction

  function automatic void end_command();
    goto_phase(PH_IDLE);
    cmd_done = 1'b1;
  endfunction

  // Counts one tick of the current phase; true on its last tick.
  function automatic bit phase_over(int unsigned len);
    int unsigned nxt;
    nxt = phase_ticks + 1;
    if (nxt >= len) return 1'b1;
    phase_ticks = TIMER_BITS'(nxt);
    return 1'b0;
  endfunction

  // Starts the bus operation of the current step, or ends the command.
  function automatic void start_op(logic [7:0] wbyte);
    logic [1:0] op;
    logic [7:0] b;
    op = OP_END;
    b  = wbyte;
    case (cur_cmd)
      CMD_RESET: if (seq_step == 4'd0) op = OP_RESET;
      CMD_WRITE: if (seq_step == 4'd0) op = OP_WRITE;
      CMD_READ:  if (seq_step == 4'd0) op = OP_READ;
      CMD_MEASURE: begin
        // Reset, skip ROM and convert, then reset, skip ROM, read scratchpad, two reads.
        case (seq_step)
          4'd0, 4'd3: op = OP_RESET;
          4'd1, 4'd4: begin
            op = OP_WRITE;
            b  = ROM_SKIP;
          end
          4'd2: begin
            op = OP_WRITE;
            b  = FN_CONVERT;
          end
          4'd5: begin
            op = OP_WRITE;
            b  = FN_READ_SCR;
          end
          4'd6, 4'd7: op = OP_READ;
          default: op = OP_END;
        endcase
      end
      default: op = OP_END;
    endcase
    bit_pos = 3'd0;
    case (op)
      OP_RESET: goto_phase(PH_RHIGH);
      OP_WRITE: begin
        shreg = b;
        goto_phase(PH_WLOW);
      end
      OP_READ: begin
        shreg = 8'h00;
        goto_phase(PH_DLOW);
      end
      default: end_command();
    endcase
  endfunction

  // Closes a bus operation: stores a read byte and moves to the next step.
  function automatic void op_finished(bit was_read);
    if (was_read) begin
      if (cur_cmd == CMD_MEASURE && seq_step == 4'd7) value_acc[15:8] = shreg;
      else value_acc[7:0] = shreg;
    end
    if (no_presence) begin
      end_command();
      return;
    end
    seq_step = seq_step + 4'd1;
    start_op(8'h00);
  endfunction

  // Advances the model by one tick and returns the result word of that tick.
  function automatic tick_result_t next_tick(logic [2:0] cmd, logic [7:0] wdata,
                                             logic line);
    tick_result_t r;
    logic         drv;
    logic         lvl;
    logic         bit0;
    drv      = 1'b1;
    lvl      = 1'b1;
    cmd_done = 1'b0;
    bit0     = shreg[0];
    // A command starts only on an idle tick; unknown codes act as plain ticks.
    if (bus_phase == PH_IDLE && cmd >= CMD_RESET && cmd <= CMD_MEASURE) begin
      cur_cmd     = cmd;
      seq_step    = 4'd0;
      no_presence = 1'b0;
      value_acc   = 16'h0000;
      start_op(wdata);
      bit0 = shreg[0];
    end
    case (bus_phase)
      PH_RHIGH: begin
        if (phase_over(ticks_of(CFG_SHORT_SLOT))) goto_phase(PH_RLOW);
      end
      PH_RLOW: begin
        lvl = 1'b0;
        if (phase_over(ticks_of(CFG_RESET_LOW))) goto_phase(PH_RWAIT);
      end
      PH_RWAIT: begin
        drv = 1'b0;
        lvl = 1'b0;
        // A high line at the presence sample means no device answered.
        if (phase_over(ticks_of(CFG_PRESENCE_WAIT))) begin
          no_presence = line;
          goto_phase(PH_RRECOV);
        end
      end
      PH_RRECOV: begin
        drv = 1'b0;
        lvl = 1'b0;
        if (phase_over(ticks_of(CFG_RESET_RECOV))) op_finished(1'b0);
      end
      PH_WLOW: begin
        lvl = 1'b0;
        if (phase_over(bit0 ? ticks_of(CFG_SHORT_SLOT) : ticks_of(CFG_LONG_SLOT)))
          goto_phase(PH_WHIGH);
      end
      PH_WHIGH: begin
        if (phase_over(bit0 ? ticks_of(CFG_LONG_SLOT) : ticks_of(CFG_SHORT_SLOT))) begin
          shreg = shreg >> 1;
          if (bit_pos >= 3'd7) op_finished(1'b0);
          else begin
            bit_pos = bit_pos + 3'd1;
            goto_phase(PH_WLOW);
          end
        end
      end
      PH_DLOW: begin
        lvl = 1'b0;
        if (phase_over(ticks_of(CFG_SHORT_SLOT))) goto_phase(PH_DWAIT);
      end
      PH_DWAIT: begin
        drv = 1'b0;
        lvl = 1'b0;
        if (phase_over(ticks_of(CFG_READ_SAMPLE))) begin
          shreg = {line, shreg[7:1]};
          goto_phase(PH_DTAIL);
        end
      end
      PH_DTAIL: begin
        drv = 1'b0;
        lvl = 1'b0;
        if (phase_over(ticks_of(CFG_READ_TAIL))) begin
          if (bit_pos >= 3'd7) op_finished(1'b1);
          else begin
            bit_pos = bit_pos + 3'd1;
            goto_phase(PH_DLOW);
          end
        end
      end
      default: bus_phase = PH_IDLE;
    endcase
    r.drive  = drv;
    r.level  = lvl;
    r.busy   = (bus_phase != PH_IDLE);
    r.done   = cmd_done;
    r.status = no_presence;
    r.value  = value_acc;
    return r;
  endfunction

  // Compare finished words first, then register writes, then new tick words.
  always @(posedge clk_i or negedge rst_ni) begin : track_words
    tick_result_t seen;
    tick_result_t want;
    if (!rst_ni) begin
      timing[CFG_RESET_LOW]     = RST_RESET_LOW;
      timing[CFG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
      timing[CFG_RESET_RECOV]   = RST_RESET_RECOV;
      timing[CFG_SHORT_SLOT]    = RST_SHORT_SLOT;
      timing[CFG_LONG_SLOT]     = RST_LONG_SLOT;
      timing[CFG_READ_SAMPLE]   = RST_READ_SAMPLE;
      timing[CFG_READ_TAIL]     = RST_READ_TAIL;
      bus_phase       = PH_IDLE;
      phase_ticks     = '0;
      bit_pos         = 3'd0;
      shreg           = 8'h00;
      seq_step        = 4'd0;
      cur_cmd         = CMD_TICK;
      value_acc       = 16'h0000;
      no_presence     = 1'b0;
      cmd_done        = 1'b0;
      expected_words.delete();
      fail_count_o    = 0;
      pending_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = '{line_drive_i, line_level_i, busy_res_i, done_res_i, status_i,
                 read_value_i};
        if (expected_words.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: result word with none pending: %p", $time, seen);
          fail_count_o++;
        end else begin
          want = expected_words.pop_front();
          if (want.drive !== seen.drive || want.level !== seen.level ||
              want.busy !== seen.busy || want.done !== seen.done ||
              want.status !== seen.status || want.value !== seen.value) begin
            if (fail_count_o < 10)
              $display({"%0t: mismatch (expected/actual) drive %b/%b level %b/%b",
                        " busy %b/%b done %b/%b status %b/%b value %h/%h"},
                       $time, want.drive, seen.drive, want.level, seen.level,
                       want.busy, seen.busy, want.done, seen.done,
                       want.status, seen.status, want.value, seen.value);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i && cfg_index_i < NUM_CFG) timing[cfg_index_i] = cfg_data_i;
      if (in_valid_i && in_ready_i)
        expected_words.push_back(next_tick(cmd_i, write_data_i, line_in_i));
      pending_count_o = expected_words.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 1-Wire temperature master. The reset timings
// and the largest timings are checked over the opening phase of a reset
// command, which short timings then finish. Directed commands run at
// all-zero timings, then random timing sets carry random commands with a
// simulated bus line, light command noise, random idling on both channels
// and one long output hold. A checker module beside the block predicts and
// compares every word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import owtm_pkg::*;

  // How the simulated bus line answers during a command.
  typedef enum logic [1:0] {
    LINE_PRESENT,
    LINE_RANDOM,
    LINE_LOW,
    LINE_HIGH
  } line_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [2:0]           cmd_i;
  logic [7:0]           write_data_i;
  logic                 line_in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 line_drive_o;
  logic                 line_level_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic                 status_o;
  logic [15:0]          read_value_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int unsigned fail_count;
  int unsigned pending_count;

  // Handshake bookkeeping of the stimulus side.
  int unsigned words_sent;
  int unsigned words_seen;
  int unsigned done_seen;
  logic        last_busy;
  bit          idle_on;
  bit          hold_req;

  logic [CFG_W-1:0] tset [NUM_CFG];

  one_wire_temperature_master dut (.*);

  bus_master_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .cmd_i           (cmd_i),
    .write_data_i    (write_data_i),
    .line_in_i       (line_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .line_drive_i    (line_drive_o),
    .line_level_i    (line_level_o),
    .busy_res_i      (busy_res_o),
    .done_res_i      (done_res_o),
    .status_i        (status_o),
    .read_value_i    (read_value_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("testbench: FAIL");
    $finish;
  end

  // Track accepted result words for pacing and for the busy flag.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_seen++;
      last_busy = busy_res_o;
      if (done_res_o) done_seen++;
    end
  end

  // Result side: random stall bursts, and one long hold on request.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        out_ready_i <= 1'b1;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic logic line_for(line_mode_e m);
    case (m)
      LINE_PRESENT: return ($urandom_range(0, 3) == 0);
      LINE_RANDOM:  return 1'($urandom_range(0, 1));
      LINE_LOW:     return 1'b0;
      default:      return 1'b1;
    endcase
  endfunction

  // Offers one tick word, with an optional idle burst in front of it.
  task automatic send_word(logic [2:0] c, logic [7:0] d, logic l);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    write_data_i <= d;
    line_in_i    <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Issues a command and keeps the ticks coming until a command completes.
  task automatic run_command(logic [2:0] c, logic [7:0] d, line_mode_e m, bit noise);
    int unsigned mark;
    logic [2:0]  fc;
    mark = done_seen;
    send_word(c, d, line_for(m));
    while (done_seen == mark) begin
      fc = (noise && $urandom_range(0, 15) == 0) ? 3'($urandom_range(1, 7)) : CMD_TICK;
      send_word(fc, 8'($urandom), line_for(m));
    end
  endtask

  // Stops offering and waits until every result word has been taken.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (words_seen != words_sent) @(negedge clk_i);
  endtask

  // Waits for every result word, then ticks on until the sequencer is idle.
  task automatic settle();
    drain();
    while (last_busy) begin
      send_word(CMD_TICK, 8'($urandom), 1'b0);
      drain();
    end
  endtask

  // Writes the whole timing set, one register per cycle.
  task automatic load_timing();
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i  <= tset[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned mark;
    int unsigned word_goal;
    in_valid_i   <= 1'b0;
    cmd_i        <= CMD_TICK;
    write_data_i <= 8'h00;
    line_in_i    <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_RESET_LOW;
    cfg_data_i   <= '0;
    rst_ni       <= 1'b0;
    words_sent = 0;
    words_seen = 0;
    done_seen  = 0;
    last_busy  = 1'b0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset timings: the high lead-in and the start of the low pulse, then
    // shortest timings let the reset command finish.
    send_word(CMD_RESET, 8'h00, 1'b0);
    repeat (29) send_word(CMD_TICK, 8'($urandom), 1'b0);
    drain();
    foreach (tset[i]) tset[i] = CFG_W'(1);
    load_timing();
    settle();

    // Largest timings hold the lead-in of a reset command.
    foreach (tset[i]) tset[i] = '1;
    load_timing();
    send_word(CMD_RESET, 8'h00, 1'b0);
    repeat (19) send_word(CMD_TICK, 8'($urandom), 1'b0);
    drain();

    // Zero timings act as one tick; missing presence ends commands early.
    foreach (tset[i]) tset[i] = '0;
    load_timing();
    settle();
    run_command(CMD_RESET, 8'h00, LINE_HIGH, 1'b0);
    run_command(CMD_MEASURE, 8'h00, LINE_HIGH, 1'b0);
    run_command(CMD_MEASURE, 8'h00, LINE_LOW, 1'b0);
    run_command(CMD_WRITE, 8'hA5, LINE_LOW, 1'b0);
    run_command(CMD_READ, 8'h00, LINE_RANDOM, 1'b0);
    // Unknown codes on idle ticks start nothing.
    for (int k = 1; k <= 3; k++) begin
      send_word(3'(CMD_MEASURE + k), 8'hFF, 1'b1);
      send_word(CMD_TICK, 8'hFF, 1'b1);
    end
    // Commands offered while a write is running are ignored.
    mark = done_seen;
    send_word(CMD_WRITE, 8'h3C, 1'b0);
    send_word(CMD_READ, 8'hC3, 1'b1);
    send_word(CMD_RESET, 8'h00, 1'b0);
    send_word(CMD_MEASURE, 8'h00, 1'b1);
    while (done_seen == mark) send_word(CMD_TICK, 8'($urandom), 1'b0);
    settle();

    // Random timing sets with random commands; the last set runs without idling.
    for (int set_n = 0; set_n < 2; set_n++) begin
      foreach (tset[i]) tset[i] = CFG_W'($urandom_range(0, 2));
      idle_on = (set_n == 0);
      load_timing();
      if (set_n == 0) hold_req = 1'b1;
      word_goal = words_sent + ((set_n == 0) ? 50 : 70);
      while (words_sent < word_goal) begin
        line_mode_e  m;
        int unsigned pick;
        if ($urandom_range(0, 15) == 0)
          send_word(3'(CMD_MEASURE + $urandom_range(1, 3)), 8'($urandom), 1'($urandom));
        pick = $urandom_range(0, 9);
        m = (pick < 6) ? LINE_PRESENT : (pick < 8) ? LINE_RANDOM :
            (pick == 8) ? LINE_LOW : LINE_HIGH;
        run_command(3'(CMD_RESET + $urandom_range(0, 3)), 8'($urandom), m, 1'b1);
      end
      settle();
    end

    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/owtm_pkg.sv
rtl/one_wire_temperature_master.sv
test/bus_master_checker.sv
test/testbench.sv
